[design/prime_field_alu_254_unit_assert.svh]
`ifndef PRIME_FIELD_ALU_254_UNIT_ASSERT_SVH
`define PRIME_FIELD_ALU_254_UNIT_ASSERT_SVH
// implication checked on every clock edge outside reset
`define PFA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define PFA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[design/pfa_pkg.sv]
package pfa_pkg;
  localparam logic [255:0] MOD_P =
    256'h30644e72e131a029b85045b68181585d97816a916871ca8d3c208c16d87cfd47;
  localparam logic [255:0] P_MINUS_2 =
    256'h30644e72e131a029b85045b68181585d97816a916871ca8d3c208c16d87cfd45;
  localparam logic [2:0] CMD_RED = 3'd0;
  localparam logic [2:0] CMD_ADD = 3'd1;
  localparam logic [2:0] CMD_SUB = 3'd2;
  localparam logic [2:0] CMD_MUL = 3'd3;
  localparam logic [2:0] CMD_DIV = 3'd4;
  localparam logic [2:0] CMD_POW = 3'd5;

  typedef enum logic [2:0] {
    OP_NONE, OP_LOAD, OP_RED, OP_ADD, OP_SUB, OP_MSTEP, OP_MDONE, OP_ZERO
  } dp_op_e;

  // datapath commands: op and selectors for multiplier operands
  typedef struct packed {
    dp_op_e     op;
    logic [1:0] msel; // 0: acc*acc, 1: acc*a, 2: a*b, 3: acc*b
    logic [7:0] bit_idx;
    logic [7:0] exp_idx;
    logic       mstart;
    logic       acc_one;  // acc <= 1
    logic       set_err;
  } dp_cmd_t;

  typedef struct packed {
    logic a_ge;
    logic b_ge;
    logic b_zero;
    logic e_bit;
    logic pm2_bit;
  } dp_sts_t;
endpackage

[design/prime_field_alu_254_unit.sv]
// Arithmetic modulo the BN254 base prime: reduce, add, subtract, multiply,
// divide and power, one transaction at a time. Operands are first reduced by
// repeated subtraction. Multiply is a bit-serial shift-add over all 256
// multiplier bits. Power runs square-and-multiply over all 256 exponent
// bits, multiplying by the base only when the bit is set. Divide is a power
// with exponent p-2 plus a final multiply. Result is held in an output
// register until taken; a new transaction is accepted from the cycle after
// it is taken.
module prime_field_alu_254_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [519:0] s_axis_tdata, // cmd, a_limb0..3, b_limb0..3, zero pad
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [263:0] m_axis_tdata  // r_limb0..3, div_error, zero pad
);
  pfa_pkg::dp_cmd_t dcmd;
  pfa_pkg::dp_sts_t sts;
  logic busy, done, in_fire, out_fire, err;
  logic [255:0] res;

  assign s_axis_tready = !busy && !done;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = done;
  assign m_axis_tdata = {7'd0, err, res};

  pfa_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .cmd_i(s_axis_tdata[2:0]),
    .out_fire_i(out_fire), .sts_i(sts), .dcmd_o(dcmd), .busy_o(busy), .done_o(done)
  );

  // operands captured from the input when it is accepted
  logic [255:0] a_hold_q, b_hold_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_hold_q <= '0;
      b_hold_q <= '0;
    end else if (in_fire) begin
      a_hold_q <= s_axis_tdata[258:3];
      b_hold_q <= s_axis_tdata[514:259];
    end
  end

  pfa_dpath u_dp (
    .clk_i, .rst_ni, .cmd_i(dcmd), .a_i(a_hold_q), .b_i(b_hold_q),
    .sts_o(sts), .res_o(res), .err_o(err)
  );
endmodule

[design/pfa_dpath.sv]
module pfa_dpath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pfa_pkg::dp_cmd_t cmd_i,
  input  logic [255:0]    a_i,
  input  logic [255:0]    b_i,
  output pfa_pkg::dp_sts_t sts_o,
  output logic [255:0]    res_o,
  output logic            err_o
);
  logic [255:0] a_q, b_q, e_q, acc_q, mx_q, my_q, macc_q, res_q;
  logic         err_q;
  logic [255:0] mx_d, my_d;
  logic [256:0] dbl, dbl_s, addx, addx_s, addx_s2, sab, sab_s;
  logic [255:0] step1, step2, step, dif;

  assign sts_o.a_ge    = (a_q >= pfa_pkg::MOD_P);
  assign sts_o.b_ge    = (b_q >= pfa_pkg::MOD_P);
  assign sts_o.b_zero  = (b_q == '0);
  assign sts_o.e_bit   = e_q[cmd_i.exp_idx];
  assign sts_o.pm2_bit = pfa_pkg::P_MINUS_2[cmd_i.exp_idx];
  assign res_o = res_q;
  assign err_o = err_q;

  always_comb begin
    case (cmd_i.msel)
      2'd0:    begin mx_d = acc_q; my_d = acc_q; end
      2'd1:    begin mx_d = acc_q; my_d = a_q;   end
      2'd2:    begin mx_d = a_q;   my_d = b_q;   end
      default: begin mx_d = acc_q; my_d = b_q;   end
    endcase
  end

  // one shift-add step: acc = 2acc (+x)
  always_comb begin
    dbl     = {macc_q, 1'b0};
    dbl_s   = dbl - {1'b0, pfa_pkg::MOD_P};
    step1   = dbl_s[256] ? dbl[255:0] : dbl_s[255:0];
    addx    = dbl + {1'b0, mx_q};
    addx_s  = addx - {1'b0, pfa_pkg::MOD_P};
    addx_s2 = addx - {pfa_pkg::MOD_P, 1'b0};
    step2   = !addx_s2[256] ? addx_s2[255:0] :
              (!addx_s[256] ? addx_s[255:0] : addx[255:0]);
    step    = my_q[cmd_i.bit_idx] ? step2 : step1;
    sab     = {1'b0, a_q} + {1'b0, b_q};
    sab_s   = sab - {1'b0, pfa_pkg::MOD_P};
    dif     = (a_q >= b_q) ? (a_q - b_q) : (a_q - b_q + pfa_pkg::MOD_P);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0; b_q <= '0; e_q <= '0; acc_q <= '0;
      mx_q <= '0; my_q <= '0; macc_q <= '0; res_q <= '0;
      err_q <= 1'b0;
    end else begin
      if (cmd_i.acc_one) acc_q <= 256'd1;
      if (cmd_i.mstart) begin
        mx_q <= mx_d; my_q <= my_d; macc_q <= '0;
      end
      case (cmd_i.op)
        pfa_pkg::OP_LOAD: begin
          a_q <= a_i; b_q <= b_i; e_q <= b_i; err_q <= 1'b0;
        end
        pfa_pkg::OP_RED: begin
          if (a_q >= pfa_pkg::MOD_P) a_q <= a_q - pfa_pkg::MOD_P;
          if (b_q >= pfa_pkg::MOD_P) b_q <= b_q - pfa_pkg::MOD_P;
          res_q <= a_q;
        end
        pfa_pkg::OP_ADD: res_q <= sab_s[256] ? sab[255:0] : sab_s[255:0];
        pfa_pkg::OP_SUB: res_q <= dif;
        pfa_pkg::OP_MSTEP: macc_q <= step;
        pfa_pkg::OP_MDONE: begin macc_q <= step; acc_q <= step; res_q <= step; end
        pfa_pkg::OP_ZERO: begin
          res_q <= '0; err_q <= cmd_i.set_err;
        end
        default: ;
      endcase
    end
  end
endmodule

[design/pfa_ctrl.sv]
module pfa_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_fire_i,
  input  logic [2:0]       cmd_i,
  input  logic             out_fire_i,
  input  pfa_pkg::dp_sts_t sts_i,
  output pfa_pkg::dp_cmd_t dcmd_o,
  output logic             busy_o,
  output logic             done_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_RED, S_EXEC, S_PSTART, S_SQ, S_SQRUN, S_MB, S_MBRUN,
    S_FIN, S_FINRUN, S_DONE
  } state_e;
  state_e state_q, ret_q;
  logic [2:0] cmd_q;
  logic [7:0] pbit_q, mbit_q;
  logic       inv_q;
  logic       done_q;

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

  always_comb begin
    dcmd_o = '0;
    dcmd_o.op = pfa_pkg::OP_NONE;
    dcmd_o.bit_idx = pbit_q;
    dcmd_o.exp_idx = pbit_q;
    case (state_q)
      S_LOAD: dcmd_o.op = pfa_pkg::OP_LOAD;
      S_RED:  dcmd_o.op = pfa_pkg::OP_RED;
      S_EXEC: begin
        case (cmd_q)
          pfa_pkg::CMD_RED: dcmd_o.op = pfa_pkg::OP_NONE;
          pfa_pkg::CMD_ADD: dcmd_o.op = pfa_pkg::OP_ADD;
          pfa_pkg::CMD_SUB: dcmd_o.op = pfa_pkg::OP_SUB;
          pfa_pkg::CMD_MUL: begin dcmd_o.msel = 2'd2; dcmd_o.mstart = 1'b1; end
          pfa_pkg::CMD_DIV: begin
            dcmd_o.op = sts_i.b_zero ? pfa_pkg::OP_ZERO : pfa_pkg::OP_NONE;
            dcmd_o.set_err = sts_i.b_zero;
            dcmd_o.acc_one = 1'b1;
          end
          pfa_pkg::CMD_POW: dcmd_o.acc_one = 1'b1;
          default: dcmd_o.op = pfa_pkg::OP_ZERO;
        endcase
      end
      S_SQ: begin dcmd_o.msel = 2'd0; dcmd_o.mstart = 1'b1; end
      S_MB: begin dcmd_o.msel = inv_q ? 2'd3 : 2'd1; dcmd_o.mstart = 1'b1; end
      S_FIN: begin dcmd_o.msel = 2'd1; dcmd_o.mstart = 1'b1; end
      S_SQRUN, S_MBRUN, S_FINRUN: begin
        dcmd_o.bit_idx = mbit_q;
        dcmd_o.op = pfa_pkg::OP_MSTEP;
      end
      default: ;
    endcase
    if ((state_q == S_SQRUN || state_q == S_MBRUN || state_q == S_FINRUN)
        && mbit_q == 8'd0)
      dcmd_o.op = pfa_pkg::OP_MDONE;
  end

  // divide raises b to p-2, then multiplies the inverse by a
  logic ebit;
  assign ebit = inv_q ? sts_i.pm2_bit : sts_i.e_bit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; ret_q <= S_IDLE; cmd_q <= '0;
      pbit_q <= '0; mbit_q <= '0; inv_q <= 1'b0; done_q <= 1'b0;
    end else begin
      if (out_fire_i) done_q <= 1'b0;
      case (state_q)
        S_IDLE: if (in_fire_i) begin cmd_q <= cmd_i; state_q <= S_LOAD; end
        S_LOAD: state_q <= S_RED;
        S_RED: if (!sts_i.a_ge && !sts_i.b_ge) state_q <= S_EXEC;
        S_EXEC: begin
          pbit_q <= 8'd255; mbit_q <= 8'd255;
          inv_q <= (cmd_q == pfa_pkg::CMD_DIV);
          case (cmd_q)
            pfa_pkg::CMD_MUL: begin ret_q <= S_DONE; state_q <= S_FINRUN; end
            pfa_pkg::CMD_DIV:
              state_q <= sts_i.b_zero ? S_DONE : S_SQ;
            pfa_pkg::CMD_POW: state_q <= S_SQ;
            default: state_q <= S_DONE;
          endcase
        end
        S_SQ: begin mbit_q <= 8'd255; state_q <= S_SQRUN; end
        S_MB: begin mbit_q <= 8'd255; state_q <= S_MBRUN; end
        S_SQRUN: begin
          mbit_q <= mbit_q - 8'd1;
          if (mbit_q == 8'd0) state_q <= ebit ? S_MB : S_PSTART;
        end
        S_MBRUN: begin
          mbit_q <= mbit_q - 8'd1;
          if (mbit_q == 8'd0) state_q <= S_PSTART;
        end
        S_PSTART: begin
          pbit_q <= pbit_q - 8'd1;
          if (pbit_q == 8'd0) state_q <= inv_q ? S_FIN : S_DONE;
          else state_q <= S_SQ;
        end
        S_FIN: begin mbit_q <= 8'd255; ret_q <= S_DONE; state_q <= S_FINRUN; end
        S_FINRUN: begin
          mbit_q <= mbit_q - 8'd1;
          if (mbit_q == 8'd0) state_q <= ret_q;
        end
        S_DONE: begin done_q <= 1'b1; state_q <= S_IDLE; end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`include "prime_field_alu_254_unit_assert.svh"
  `PFA_ASSERT_IMP(a_idle_not_done, done_q, state_q == S_IDLE)
  `PFA_ASSERT_NXT(a_done_next, state_q == S_DONE, done_q)
  `PFA_ASSERT_IMP(a_exec_reduced, state_q == S_EXEC, !sts_i.a_ge && !sts_i.b_ge)
endmodule
